### design/rvenc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvenc_pkg: shared types and constants of the RV64IM instruction encoder
// Holds the opcodes, the command codes, the funct3/funct7 lookup tables and
// the structures that carry a decoded operation down the pipeline.
// ----------------------------------------------------------------------------
package rvenc_pkg;

  // Major opcodes.
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_REG32  = 7'h3B;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;

  // Fixed system words.
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  // Registers used by the call expansion.
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_T1   = 5'd6;

  // Command codes that the decoder compares against.
  localparam logic [5:0] CMD_ADDW   = 6'd10;
  localparam logic [5:0] CMD_SUBW   = 6'd11;
  localparam logic [5:0] CMD_REMU   = 6'd17;
  localparam logic [5:0] CMD_ADDI   = 6'd18;
  localparam logic [5:0] CMD_SLTIU  = 6'd23;
  localparam logic [5:0] CMD_SLLI   = 6'd24;
  localparam logic [5:0] CMD_SRAI   = 6'd26;
  localparam logic [5:0] CMD_LD     = 6'd27;
  localparam logic [5:0] CMD_LBU    = 6'd33;
  localparam logic [5:0] CMD_SD     = 6'd34;
  localparam logic [5:0] CMD_SB     = 6'd37;
  localparam logic [5:0] CMD_BEQ    = 6'd38;
  localparam logic [5:0] CMD_BGEU   = 6'd43;
  localparam logic [5:0] CMD_JAL    = 6'd44;
  localparam logic [5:0] CMD_JALR   = 6'd45;
  localparam logic [5:0] CMD_LUI    = 6'd46;
  localparam logic [5:0] CMD_AUIPC  = 6'd47;
  localparam logic [5:0] CMD_LI     = 6'd48;
  localparam logic [5:0] CMD_CALL   = 6'd49;
  localparam logic [5:0] CMD_ECALL  = 6'd50;
  localparam logic [5:0] CMD_EBREAK = 6'd51;

  localparam logic [2:0] F3_SLLI = 3'd1;
  localparam logic [2:0] F3_SRXI = 3'd5;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MUL  = 7'h01;

  typedef enum logic [3:0] {
    FMT_R, FMT_I, FMT_SH, FMT_S, FMT_B, FMT_J, FMT_U,
    FMT_LI, FMT_CALL, FMT_ECALL, FMT_EBREAK
  } fmt_e;

  // Result of decoding one command.
  typedef struct packed {
    fmt_e       fmt;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [6:0] opc;
    logic       li_small;   // li immediate fits a 12-bit signed field
    logic       li_in32;    // li immediate fits signed 32 bits
    logic       call_near;  // call offset reachable by JAL
    logic       lo_zero;    // low 12 immediate bits are zero
  } dec_t;

  // Contents of the first pipeline stage.
  typedef struct packed {
    dec_t        dec;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } s1_t;

  // Contents of the second pipeline stage.
  typedef struct packed {
    s1_t         op;
    logic [19:0] hi;        // upper part rounded for a following low part
  } s2_t;

  function automatic logic [6:0] r_f7(input logic [4:0] idx);
    logic [6:0] f;
    unique case (idx)
      5'd1, 5'd7, 5'd11: f = F7_ALT;
      5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17: f = F7_MUL;
      default: f = 7'h00;
    endcase
    return f;
  endfunction

  function automatic logic [2:0] r_f3(input logic [4:0] idx);
    logic [2:0] f;
    unique case (idx)
      5'd2:  f = 3'd7;
      5'd3:  f = 3'd6;
      5'd4:  f = 3'd4;
      5'd5:  f = 3'd1;
      5'd6:  f = 3'd5;
      5'd7:  f = 3'd5;
      5'd8:  f = 3'd2;
      5'd9:  f = 3'd3;
      5'd13: f = 3'd1;
      5'd14: f = 3'd4;
      5'd15: f = 3'd5;
      5'd16: f = 3'd6;
      5'd17: f = 3'd7;
      default: f = 3'd0;
    endcase
    return f;
  endfunction

  function automatic logic [2:0] i_f3(input logic [2:0] idx);
    logic [2:0] f;
    unique case (idx)
      3'd1: f = 3'd7;
      3'd2: f = 3'd6;
      3'd3: f = 3'd4;
      3'd4: f = 3'd2;
      3'd5: f = 3'd3;
      default: f = 3'd0;
    endcase
    return f;
  endfunction

  function automatic logic [2:0] ld_f3(input logic [2:0] idx);
    logic [2:0] f;
    unique case (idx)
      3'd0: f = 3'd3;
      3'd1: f = 3'd2;
      3'd2: f = 3'd6;
      3'd3: f = 3'd1;
      3'd4: f = 3'd5;
      3'd5: f = 3'd0;
      default: f = 3'd4;
    endcase
    return f;
  endfunction

  function automatic logic [2:0] st_f3(input logic [1:0] idx);
    return 3'd3 - {1'b0, idx};
  endfunction

  function automatic logic [2:0] br_f3(input logic [2:0] idx);
    logic [2:0] f;
    unique case (idx)
      3'd0: f = 3'd0;
      3'd1: f = 3'd1;
      3'd2: f = 3'd4;
      3'd3: f = 3'd5;
      3'd4: f = 3'd6;
      default: f = 3'd7;
    endcase
    return f;
  endfunction

endpackage

### design/rvenc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvenc_decode: command decode and immediate range checks
// Maps the command code to an instruction format and its function fields,
// and classifies the immediate for the li and call expansions.
// ----------------------------------------------------------------------------
module rvenc_decode (
  input  logic [5:0]         cmd_i,
  input  logic [63:0]        imm_i,
  output logic               known_o,
  output rvenc_pkg::dec_t    dec_o
);
  import rvenc_pkg::*;

  logic [5:0] rel;

  always_comb begin
    dec_o           = '0;
    dec_o.fmt       = FMT_R;
    known_o         = 1'b1;
    rel             = 6'd0;
    // Wide sign checks: all bits above the field equal the field's sign bit.
    dec_o.li_small  = (&imm_i[63:11]) | ~(|imm_i[63:11]);
    dec_o.li_in32   = (&imm_i[63:31]) | ~(|imm_i[63:31]);
    dec_o.call_near = (&imm_i[31:20]) | ~(|imm_i[31:20]);
    dec_o.lo_zero   = ~(|imm_i[11:0]);
    priority if (cmd_i <= CMD_REMU) begin
      dec_o.fmt = FMT_R;
      dec_o.f7  = r_f7(cmd_i[4:0]);
      dec_o.f3  = r_f3(cmd_i[4:0]);
      dec_o.opc = (cmd_i == CMD_ADDW || cmd_i == CMD_SUBW) ? OPC_REG32 : OPC_REG;
    end else if (cmd_i <= CMD_SLTIU) begin
      rel       = cmd_i - CMD_ADDI;
      dec_o.fmt = FMT_I;
      dec_o.f3  = i_f3(rel[2:0]);
      dec_o.opc = OPC_IMM;
    end else if (cmd_i <= CMD_SRAI) begin
      dec_o.fmt = FMT_SH;
      dec_o.f3  = (cmd_i == CMD_SLLI) ? F3_SLLI : F3_SRXI;
      dec_o.f7  = (cmd_i == CMD_SRAI) ? F7_ALT : 7'h00;
      dec_o.opc = OPC_IMM;
    end else if (cmd_i <= CMD_LBU) begin
      rel       = cmd_i - CMD_LD;
      dec_o.fmt = FMT_I;
      dec_o.f3  = ld_f3(rel[2:0]);
      dec_o.opc = OPC_LOAD;
    end else if (cmd_i <= CMD_SB) begin
      rel       = cmd_i - CMD_SD;
      dec_o.fmt = FMT_S;
      dec_o.f3  = st_f3(rel[1:0]);
      dec_o.opc = OPC_STORE;
    end else if (cmd_i <= CMD_BGEU) begin
      rel       = cmd_i - CMD_BEQ;
      dec_o.fmt = FMT_B;
      dec_o.f3  = br_f3(rel[2:0]);
      dec_o.opc = OPC_BRANCH;
    end else if (cmd_i == CMD_JAL) begin
      dec_o.fmt = FMT_J;
      dec_o.opc = OPC_JAL;
    end else if (cmd_i == CMD_JALR) begin
      dec_o.fmt = FMT_I;
      dec_o.opc = OPC_JALR;
    end else if (cmd_i == CMD_LUI) begin
      dec_o.fmt = FMT_U;
      dec_o.opc = OPC_LUI;
    end else if (cmd_i == CMD_AUIPC) begin
      dec_o.fmt = FMT_U;
      dec_o.opc = OPC_AUIPC;
    end else if (cmd_i == CMD_LI) begin
      dec_o.fmt = FMT_LI;
    end else if (cmd_i == CMD_CALL) begin
      dec_o.fmt = FMT_CALL;
    end else if (cmd_i == CMD_ECALL) begin
      dec_o.fmt = FMT_ECALL;
    end else if (cmd_i == CMD_EBREAK) begin
      dec_o.fmt = FMT_EBREAK;
    end else begin
      known_o = 1'b0;
    end
  end

endmodule

### design/rvenc_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvenc_pack: instruction word assembly
// Packs the decoded fields into the first and, for the two-word expansions,
// the second machine word, and flags an li immediate that is out of range.
// ----------------------------------------------------------------------------
module rvenc_pack (
  input  rvenc_pkg::s2_t s2_i,
  output logic [31:0]    w0_o,
  output logic [31:0]    w1_o,
  output logic           two_o,
  output logic           err_o
);
  import rvenc_pkg::*;

  logic [4:0]  d, a, b;
  logic [31:0] i;
  dec_t        dc;

  assign d  = s2_i.op.rd;
  assign a  = s2_i.op.rs1;
  assign b  = s2_i.op.rs2;
  assign i  = s2_i.op.imm;
  assign dc = s2_i.op.dec;

  always_comb begin
    w0_o  = '0;
    w1_o  = '0;
    two_o = 1'b0;
    err_o = 1'b0;
    unique case (dc.fmt)
      FMT_R:  w0_o = {dc.f7, b, a, dc.f3, d, dc.opc};
      FMT_I:  w0_o = {i[11:0], a, dc.f3, d, dc.opc};
      FMT_SH: w0_o = {dc.f7[6:1], i[5:0], a, dc.f3, d, dc.opc};
      FMT_S:  w0_o = {i[11:5], b, a, dc.f3, i[4:0], OPC_STORE};
      FMT_B:  w0_o = {i[12], i[10:5], b, a, dc.f3, i[4:1], i[11], OPC_BRANCH};
      FMT_J:  w0_o = {i[20], i[10:1], i[11], i[19:12], d, OPC_JAL};
      FMT_U:  w0_o = {i[19:0], d, dc.opc};
      FMT_LI: begin
        priority if (dc.li_small) begin
          w0_o = {i[11:0], REG_ZERO, 3'd0, d, OPC_IMM};
        end else if (!dc.li_in32) begin
          err_o = 1'b1;
        end else begin
          // With the low part zero the rounded upper part equals imm[31:12].
          w0_o  = {s2_i.hi, d, OPC_LUI};
          w1_o  = {i[11:0], d, 3'd0, d, OPC_IMM};
          two_o = !dc.lo_zero;
        end
      end
      FMT_CALL: begin
        if (dc.call_near) begin
          w0_o = {i[20], i[10:1], i[11], i[19:12], REG_RA, OPC_JAL};
        end else begin
          w0_o  = {s2_i.hi, REG_T1, OPC_AUIPC};
          w1_o  = {i[11:0], REG_T1, 3'd0, REG_RA, OPC_JALR};
          two_o = 1'b1;
        end
      end
      FMT_ECALL:  w0_o = WORD_ECALL;
      FMT_EBREAK: w0_o = WORD_EBREAK;
      default:    w0_o = '0;
    endcase
  end

endmodule

### design/rv64_instruction_encoder_top.sv
`timescale 1ns / 1ps
// A transaction's first word passes through stages 1, 2 and 3 and is offered
// on the output port from the stage 3 register.
// Throughput: one input transaction per cycle for single-word operations while
// the output does not stall; the two-word li and far call expansions hold stage
// 3 until their second word is taken, since the output port carries one word per
// cycle. Reset (rst_ni low, asynchronous) empties every stage; the block takes input as soon as reset is released.
// ----------------------------------------------------------------------------
// rv64_instruction_encoder_top: RV64IM instruction encoder
// Three register stages (decode, upper-part rounding, word assembly), the last
// of which doubles as the output stage, hand out one or two words per transaction.
// ----------------------------------------------------------------------------
module rv64_instruction_encoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [5:0]         cmd_i,
  input  logic [4:0]         rd_i,
  input  logic [4:0]         rs1_i,
  input  logic [4:0]         rs2_i,
  input  logic signed [63:0] imm_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        instr_o,
  output logic               last_o,
  output logic               error_o
);
  import rvenc_pkg::*;

  // Stage 1: decoded command, register numbers and the low immediate bits.
  // The upper 32 immediate bits only matter for the range checks, which are
  // resolved here so that they need not travel further.
  logic  known;
  dec_t  dec;
  s1_t   s1_q;
  logic  v1_q;

  // Stage 2: adds the rounded upper part used by LUI and AUIPC expansions.
  s2_t   s2_q, s2_d;
  logic  v2_q;

  // Stage 3: both output words assembled; doubles as the output register.
  logic [31:0] w0_d, w1_d, w0_q, w1_q;
  logic        two_d, err_d, two_q, err_q;
  logic        v3_q;
  logic        sel_q, sel_d;   // set while the second word is on the port

  logic en1, en2, en3, out_fire, pop;

  rvenc_decode u_decode (
    .cmd_i   (cmd_i),
    .imm_i   (imm_i),
    .known_o (known),
    .dec_o   (dec)
  );

  // A stage takes new data when it is empty or its contents move on. Stage 3
  // empties only when the last word of its transaction has been taken, so a
  // stall holds in place each full stage that has no empty stage after it.
  assign out_fire = out_valid_o && out_ready_i;
  assign pop      = out_fire && last_o;
  assign en3      = !v3_q || pop;
  assign en2      = !v2_q || en3;
  assign en1      = !v1_q || en2;
  assign in_ready_o = en1;

  // Rounding of the upper part: adding bit 11 compensates the sign-extended
  // low part that the following ADDI or JALR adds back.
  always_comb begin
    s2_d    = '0;
    s2_d.op = s1_q;
    s2_d.hi = s1_q.imm[31:12] + {19'd0, s1_q.imm[11]};
  end

  rvenc_pack u_pack (
    .s2_i  (s2_q),
    .w0_o  (w0_d),
    .w1_o  (w1_d),
    .two_o (two_d),
    .err_o (err_d)
  );

  // Word select on the output: advance to the second word once the first of
  // a two-word transaction has been taken, and return on the last.
  always_comb begin
    sel_d = sel_q;
    if (pop) begin
      sel_d = 1'b0;
    end else if (out_fire) begin
      sel_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (en1) begin
        // Unknown commands produce no word and are dropped at entry.
        v1_q <= in_valid_i && known;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q.dec <= dec;
      s1_q.rd  <= rd_i;
      s1_q.rs1 <= rs1_i;
      s1_q.rs2 <= rs2_i;
      s1_q.imm <= imm_i[31:0];
    end
    if (en2) begin
      s2_q <= s2_d;
    end
    if (en3) begin
      w0_q  <= w0_d;
      w1_q  <= w1_d;
      two_q <= two_d;
      err_q <= err_d;
    end
  end

  assign out_valid_o = v3_q;
  assign instr_o     = sel_q ? w1_q : w0_q;
  assign last_o      = !two_q || sel_q;
  assign error_o     = err_q;

endmodule

### design/rvenc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvenc_checker: port-level checks for the instruction encoder
// Watches the output port for consistent error reporting and for the second
// word of a two-word transaction following at once.
// ----------------------------------------------------------------------------
module rvenc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] instr_o,
  input logic        last_o,
  input logic        error_o
);

  // An error transaction is a single zero word.
  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (last_o && instr_o == 32'd0))
    else $error("error word is not a single zero word");

  // The second word of an expansion is ready in the very next cycle.
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("second word did not follow");

  // Expansions are at most two words and never carry the error flag.
  a_second_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> (last_o && !error_o))
    else $error("second word is not final or flags an error");

  // Nothing is offered right after reset is released.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid straight after reset");

endmodule

bind rv64_instruction_encoder_top rvenc_checker u_rvenc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .instr_o     (instr_o),
  .last_o      (last_o),
  .error_o     (error_o)
);

### tb/sv/tb_rv64_instruction_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv64_instruction_encoder_top: self-checking bench for the RV64IM encoder
// Drives operations through the valid/ready input port and predicts the one
// or two machine words of each transaction. Every word handed out is checked
// against the oldest prediction, while the input idles at random and the output stalls.
// ----------------------------------------------------------------------------
module tb_rv64_instruction_encoder_top;

  import rvenc_pkg::*;

  // Operations in the order of the command field. Codes above the last one
  // are unused and are dropped by the block without an answer.
  typedef enum logic [5:0] {
    C_ADD, C_SUB, C_AND, C_OR, C_XOR, C_SLL, C_SRL, C_SRA, C_SLT, C_SLTU,
    C_ADDW, C_SUBW, C_MUL, C_MULH, C_DIV, C_DIVU, C_REM, C_REMU,
    C_ADDI, C_ANDI, C_ORI, C_XORI, C_SLTI, C_SLTIU,
    C_SLLI, C_SRLI, C_SRAI,
    C_LD, C_LW, C_LWU, C_LH, C_LHU, C_LB, C_LBU,
    C_SD, C_SW, C_SH, C_SB,
    C_BEQ, C_BNE, C_BLT, C_BGE, C_BLTU, C_BGEU,
    C_JAL, C_JALR, C_LUI, C_AUIPC, C_LI, C_CALL, C_ECALL, C_EBREAK
  } op_e;

  localparam logic [5:0] CMD_FIRST_UNUSED = 6'd52;
  localparam logic [5:0] CMD_LAST_UNUSED  = 6'd63;

  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 20;
  // This limit leaves ample room for the slowest correct run.
  localparam int CYCLE_LIMIT  = 500000;

  // One expected output word.
  typedef struct packed {
    logic [31:0] instr;
    logic        last;
    logic        error;
  } word_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [5:0]         cmd_i       = '0;
  logic [4:0]         rd_i        = '0;
  logic [4:0]         rs1_i       = '0;
  logic [4:0]         rs2_i       = '0;
  logic signed [63:0] imm_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [31:0]        instr_o;
  logic               last_o;
  logic               error_o;

  word_t pending_words[$];
  int    n_fail      = 0;
  int    cycle_count = 0;
  int    burst_left  = 0;

  rv64_instruction_encoder_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .rd_i       (rd_i),
    .rs1_i      (rs1_i),
    .rs2_i      (rs2_i),
    .imm_i      (imm_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .instr_o    (instr_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Word formats. The immediate arguments are already cut to the bits that
  // each format holds, so the truncation happens at the call.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] r_word(input logic [6:0] f7, input logic [2:0] f3,
                                         input logic [4:0] rs2, input logic [4:0] rs1,
                                         input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] i_word(input logic [11:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] s_word(input logic [11:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] b_word(input logic [12:0] off, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] j_word(input logic [20:0] off, input logic [4:0] rd);
    return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] u_word(input logic [19:0] imm, input logic [4:0] rd,
                                         input logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  function automatic void queue_word(input logic [31:0] w, input logic last,
                                     input logic err);
    pending_words.push_back({w, last, err});
  endfunction

  // --------------------------------------------------------------------------
  // Works out the words that one accepted transaction must produce and
  // appends them to the queue of pending words.
  // --------------------------------------------------------------------------
  function automatic void encode_op(input logic [5:0] cmd, input logic [4:0] rd,
                                    input logic [4:0] rs1, input logic [4:0] rs2,
                                    input logic [63:0] imm);
    logic [31:0]        w;
    logic               single;
    logic signed [63:0] simm;
    logic signed [31:0] soff;
    logic [19:0]        hi;

    w      = '0;
    single = 1'b1;
    simm   = imm;
    soff   = imm[31:0];
    // Upper part rounded up whenever the sign-extended low part is negative.
    hi     = imm[31:12] + {19'd0, imm[11]};

    case (cmd)
      C_ADD:   w = r_word(7'h00, 3'd0, rs2, rs1, rd, OPC_REG);
      C_SUB:   w = r_word(7'h20, 3'd0, rs2, rs1, rd, OPC_REG);
      C_AND:   w = r_word(7'h00, 3'd7, rs2, rs1, rd, OPC_REG);
      C_OR:    w = r_word(7'h00, 3'd6, rs2, rs1, rd, OPC_REG);
      C_XOR:   w = r_word(7'h00, 3'd4, rs2, rs1, rd, OPC_REG);
      C_SLL:   w = r_word(7'h00, 3'd1, rs2, rs1, rd, OPC_REG);
      C_SRL:   w = r_word(7'h00, 3'd5, rs2, rs1, rd, OPC_REG);
      C_SRA:   w = r_word(7'h20, 3'd5, rs2, rs1, rd, OPC_REG);
      C_SLT:   w = r_word(7'h00, 3'd2, rs2, rs1, rd, OPC_REG);
      C_SLTU:  w = r_word(7'h00, 3'd3, rs2, rs1, rd, OPC_REG);
      C_ADDW:  w = r_word(7'h00, 3'd0, rs2, rs1, rd, OPC_REG32);
      C_SUBW:  w = r_word(7'h20, 3'd0, rs2, rs1, rd, OPC_REG32);
      C_MUL:   w = r_word(7'h01, 3'd0, rs2, rs1, rd, OPC_REG);
      C_MULH:  w = r_word(7'h01, 3'd1, rs2, rs1, rd, OPC_REG);
      C_DIV:   w = r_word(7'h01, 3'd4, rs2, rs1, rd, OPC_REG);
      C_DIVU:  w = r_word(7'h01, 3'd5, rs2, rs1, rd, OPC_REG);
      C_REM:   w = r_word(7'h01, 3'd6, rs2, rs1, rd, OPC_REG);
      C_REMU:  w = r_word(7'h01, 3'd7, rs2, rs1, rd, OPC_REG);
      C_ADDI:  w = i_word(imm[11:0], rs1, 3'd0, rd, OPC_IMM);
      C_ANDI:  w = i_word(imm[11:0], rs1, 3'd7, rd, OPC_IMM);
      C_ORI:   w = i_word(imm[11:0], rs1, 3'd6, rd, OPC_IMM);
      C_XORI:  w = i_word(imm[11:0], rs1, 3'd4, rd, OPC_IMM);
      C_SLTI:  w = i_word(imm[11:0], rs1, 3'd2, rd, OPC_IMM);
      C_SLTIU: w = i_word(imm[11:0], rs1, 3'd3, rd, OPC_IMM);
      // Shift amounts take six bits; the arithmetic shift sets bit 30.
      C_SLLI:  w = i_word({6'h00, imm[5:0]}, rs1, 3'd1, rd, OPC_IMM);
      C_SRLI:  w = i_word({6'h00, imm[5:0]}, rs1, 3'd5, rd, OPC_IMM);
      C_SRAI:  w = i_word({6'h10, imm[5:0]}, rs1, 3'd5, rd, OPC_IMM);
      C_LD:    w = i_word(imm[11:0], rs1, 3'd3, rd, OPC_LOAD);
      C_LW:    w = i_word(imm[11:0], rs1, 3'd2, rd, OPC_LOAD);
      C_LWU:   w = i_word(imm[11:0], rs1, 3'd6, rd, OPC_LOAD);
      C_LH:    w = i_word(imm[11:0], rs1, 3'd1, rd, OPC_LOAD);
      C_LHU:   w = i_word(imm[11:0], rs1, 3'd5, rd, OPC_LOAD);
      C_LB:    w = i_word(imm[11:0], rs1, 3'd0, rd, OPC_LOAD);
      C_LBU:   w = i_word(imm[11:0], rs1, 3'd4, rd, OPC_LOAD);
      C_SD:    w = s_word(imm[11:0], rs2, rs1, 3'd3);
      C_SW:    w = s_word(imm[11:0], rs2, rs1, 3'd2);
      C_SH:    w = s_word(imm[11:0], rs2, rs1, 3'd1);
      C_SB:    w = s_word(imm[11:0], rs2, rs1, 3'd0);
      C_BEQ:   w = b_word(imm[12:0], rs2, rs1, 3'd0);
      C_BNE:   w = b_word(imm[12:0], rs2, rs1, 3'd1);
      C_BLT:   w = b_word(imm[12:0], rs2, rs1, 3'd4);
      C_BGE:   w = b_word(imm[12:0], rs2, rs1, 3'd5);
      C_BLTU:  w = b_word(imm[12:0], rs2, rs1, 3'd6);
      C_BGEU:  w = b_word(imm[12:0], rs2, rs1, 3'd7);
      C_JAL:   w = j_word(imm[20:0], rd);
      C_JALR:  w = i_word(imm[11:0], rs1, 3'd0, rd, OPC_JALR);
      C_LUI:   w = u_word(imm[19:0], rd, OPC_LUI);
      C_AUIPC: w = u_word(imm[19:0], rd, OPC_AUIPC);
      C_LI: begin
        if (simm >= -64'sd2048 && simm <= 64'sd2047) begin
          w = i_word(imm[11:0], REG_ZERO, 3'd0, rd, OPC_IMM);
        end else if (simm < -64'sd2147483648 || simm > 64'sd2147483647) begin
          // Beyond signed 32 bits: a single flagged word of zero.
          single = 1'b0;
          queue_word(32'h0, 1'b1, 1'b1);
        end else if (imm[11:0] == 12'h000) begin
          w = u_word(imm[31:12], rd, OPC_LUI);
        end else begin
          single = 1'b0;
          queue_word(u_word(hi, rd, OPC_LUI), 1'b0, 1'b0);
          queue_word(i_word(imm[11:0], rd, 3'd0, rd, OPC_IMM), 1'b1, 1'b0);
        end
      end
      C_CALL: begin
        // Only the low 32 bits of the offset count; the registers are fixed.
        if (soff >= -32'sd1048576 && soff < 32'sd1048576) begin
          w = j_word(imm[20:0], REG_RA);
        end else begin
          single = 1'b0;
          queue_word(u_word(hi, REG_T1, OPC_AUIPC), 1'b0, 1'b0);
          queue_word(i_word(imm[11:0], REG_T1, 3'd0, REG_RA, OPC_JALR), 1'b1, 1'b0);
        end
      end
      C_ECALL:  w = WORD_ECALL;
      C_EBREAK: w = WORD_EBREAK;
      default:  single = 1'b0;
    endcase

    if (single) begin
      queue_word(w, 1'b1, 1'b0);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Every accepted input transaction is predicted, and every
  // accepted output transaction is compared with the oldest prediction.
  // Values are read at the clock edge, before the nonblocking updates of
  // that edge land, so the order of processes within the step is irrelevant.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    word_t exp_w;

    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: instr %h last %b error %b", instr_o, last_o, error_o);
        n_fail++;
      end else begin
        exp_w = pending_words.pop_front();
        if (instr_o !== exp_w.instr) begin
          $error("instr: expected %h, got %h", exp_w.instr, instr_o);
          n_fail++;
        end
        if (last_o !== exp_w.last) begin
          $error("last: expected %b, got %b", exp_w.last, last_o);
          n_fail++;
        end
        if (error_o !== exp_w.error) begin
          $error("error: expected %b, got %b", exp_w.error, error_o);
          n_fail++;
        end
      end
    end
    // Every input is registered before it reaches the output, so predicting after the check is safe.
    if (rst_ni && in_valid_i && in_ready_o) begin
      encode_op(cmd_i, rd_i, rs1_i, rs2_i, imm_i);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure and the watchdog. The stall pattern moves through
  // four modes in turn: always ready, random stalls, a fixed duty cycle, and
  // long stalls, so that stalls land on both words of a two-word transaction
  // as well as between transactions.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count++;
    case ((cycle_count / 256) % 4)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= (cycle_count % 5) < 3;
      default: out_ready_i <= (cycle_count % 32) >= 12;
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rv64_instruction_encoder_top: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sends one input transaction. The sender works in bursts; between bursts
  // valid drops for a random gap, and a quarter of the bursts follow on with
  // no gap at all. Valid stays high from one transaction to the next within
  // a burst. The task is entered and left at a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_op(input logic [5:0] cmd, input logic [4:0] rd,
                         input logic [4:0] rs1, input logic [4:0] rs2,
                         input logic [63:0] imm);
    int gap;

    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    cmd_i      <= cmd;
    rd_i       <= rd;
    rs1_i      <= rs1;
    rs2_i      <= rs2;
    imm_i      <= imm;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Field extremes: all-zero and all-one registers and immediates.
  task automatic test_field_extremes();
    send_op(C_ADD, 5'd0, 5'd0, 5'd0, 64'h0);
    send_op(C_REMU, 5'd31, 5'd31, 5'd31, '1);
    send_op(C_SRAI, 5'd31, 5'd31, 5'd0, '1);
    send_op(C_SD, 5'd0, 5'd31, 5'd31, 64'h8000_0000_0000_07FF);
    send_op(C_BGEU, 5'd31, 5'd0, 5'd31, 64'h7FFF_FFFF_FFFF_F800);
  endtask

  // Load-immediate: the small form at both ends, the upper-only form, the
  // general pair with rounding of the upper part, and values just outside
  // the signed 32-bit range.
  task automatic test_load_immediate();
    send_op(C_LI, 5'd5, 5'd9, 5'd3, 64'sd2047);
    send_op(C_LI, 5'd31, 5'd0, 5'd0, -64'sd2048);
    send_op(C_LI, 5'd7, 5'd1, 5'd2, 64'sd2048);
    send_op(C_LI, 5'd10, 5'd0, 5'd0, 64'h1000);
    send_op(C_LI, 5'd11, 5'd4, 5'd4, -64'sd2147483648);
    send_op(C_LI, 5'd12, 5'd0, 5'd0, 64'sd2147483647);
    send_op(C_LI, 5'd13, 5'd0, 5'd0, 64'sd2147483648);
    send_op(C_LI, 5'd14, 5'd0, 5'd0, -64'sd2147483649);
    send_op(C_LI, 5'd15, 5'd0, 5'd0, 64'h8000_0000_0000_0000);
  endtask

  // Call: offsets at both edges of the near reach, just beyond them, a far
  // offset whose low part rounds the upper part, and an offset whose upper
  // 32 bits must be ignored.
  task automatic test_call();
    send_op(C_CALL, 5'd0, 5'd0, 5'd0, 64'h0);
    send_op(C_CALL, 5'd17, 5'd3, 5'd8, 64'sd1048574);
    send_op(C_CALL, 5'd0, 5'd0, 5'd0, -64'sd1048576);
    send_op(C_CALL, 5'd0, 5'd0, 5'd0, 64'sd1048576);
    send_op(C_CALL, 5'd0, 5'd0, 5'd0, -64'sd1048578);
    send_op(C_CALL, 5'd9, 5'd9, 5'd9, 64'h1234_5800);
    send_op(C_CALL, 5'd0, 5'd0, 5'd0, 64'hDEAD_BEEF_0000_0800);
  endtask

  // System words, whose operand fields are ignored, and unused codes, which
  // must produce nothing.
  task automatic test_system_and_unused();
    send_op(C_ECALL, 5'd31, 5'd31, 5'd31, '1);
    send_op(C_EBREAK, 5'd21, 5'd10, 5'd5, 64'h5555_5555_5555_5555);
    send_op(CMD_FIRST_UNUSED, 5'd1, 5'd2, 5'd3, 64'h10);
    send_op(CMD_LAST_UNUSED, 5'd31, 5'd31, 5'd31, '1);
  endtask

  // Random operations. The immediate is drawn from several shapes so that
  // the format edges (12-bit, 21-bit and 32-bit boundaries, zero low parts,
  // rounding of the upper part) are hit often, alongside fully random words.
  // Transactions with an unused code are sent now and then but not counted.
  task automatic test_random_ops();
    int          n_sent;
    logic [5:0]  cmd;
    logic [31:0] r;
    logic [31:0] edge_off;
    logic [63:0] imm;

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        cmd = 6'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
      end else begin
        cmd = 6'($urandom_range(C_ADD, C_EBREAK));
      end
      r = $urandom;
      case ($urandom_range(0, 7))
        0: imm = {$urandom, $urandom};
        1: imm = {{52{r[11]}}, r[11:0]};
        2: imm = {{32{r[31]}}, r};
        3: imm = {{32{r[31]}}, r[31:12], 12'h000};
        4: begin
          edge_off = (r[0] ? 32'h0010_0000 : 32'hFFF0_0000) + $urandom_range(0, 8) - 4;
          imm = {$urandom, edge_off};
        end
        5: imm = (r[0] ? 64'h0000_0000_7FFF_FFFF : 64'hFFFF_FFFF_8000_0000)
                 + $urandom_range(0, 8) - 4;
        6: imm = {{43{r[20]}}, r[20:0]};
        default: imm = {{32{r[31]}}, r[31:12], 1'b1, r[10:0]};
      endcase
      send_op(cmd, 5'($urandom), 5'($urandom), 5'($urandom), imm);
      if (cmd <= C_EBREAK) begin
        n_sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset once, run the tests in turn, drain, then report.
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_load_immediate();
    test_call();
    test_system_and_unused();
    test_random_ops();
    in_valid_i <= 1'b0;

    // Wait for every predicted word, then a little longer to catch strays.
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("rv64_instruction_encoder_top: match");
    end else begin
      $display("rv64_instruction_encoder_top: mismatch");
    end
    $finish;
  end

endmodule
